// ===== src/rti_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_pkg
// Shared constants and types for the ray / triangle intersection pipeline.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int DIST_WIDTH_DEF  = 32;

  // fraction bits of the distance and scale of the normal before the root
  localparam int T_FRAC    = 16;
  localparam int NRM_SHIFT = 28;

  // normal components: Q1.14 in 16 bits
  localparam int NRM_W = 16;
  localparam logic [NRM_W-1:0] NRM_ONE = NRM_W'(16384);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C = 2'd2;

  // control flags leaving the determinant front end
  typedef struct packed {
    logic valid;
    logic ok;    // D nonzero and both weights inside the triangle
    logic ovf;   // distance quotient does not fit DIST_WIDTH bits
    logic tneg;  // distance is negative
  } rti_ctl_t;

endpackage
`default_nettype wire

// ===== src/rti_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_div
// Pipelined restoring divider, one quotient bit per stage. The caller keeps
// the quotient below 2**Q_W. Side data travels alongside.
// ----------------------------------------------------------------------------
module rti_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 32,
  parameter int Q_W   = 16,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [SB_W-1:0]  sb_in,
  output logic             out_vld,
  output logic [Q_W-1:0]   quo,
  output logic [SB_W-1:0]  sb_out
);

  localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic             vld_r [Q_W];
  logic [W-1:0]     rem_r [Q_W];
  logic [Q_W-1:0]   quo_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [SB_W-1:0]  sb_r  [Q_W];

  genvar j;
  for (j = 0; j < Q_W; j++) begin : g_stage
    localparam int B = Q_W - 1 - j;
    logic             vld_in;
    logic [W-1:0]     rem_in;
    logic [Q_W-1:0]   quo_in;
    logic [DEN_W-1:0] den_in;
    logic [SB_W-1:0]  sb_stage;
    logic [W-1:0]     trial;
    logic [W-1:0]     rem_nxt;
    logic [Q_W-1:0]   quo_nxt;

    if (j == 0) begin : g_first
      assign vld_in   = in_vld;
      assign rem_in   = W'(num);
      assign quo_in   = '0;
      assign den_in   = den;
      assign sb_stage = sb_in;
    end else begin : g_next
      assign vld_in   = vld_r[j-1];
      assign rem_in   = rem_r[j-1];
      assign quo_in   = quo_r[j-1];
      assign den_in   = den_r[j-1];
      assign sb_stage = sb_r[j-1];
    end

    always_comb begin
      trial   = W'(den_in) << B;
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      if (rem_in >= trial) begin
        rem_nxt    = rem_in - trial;
        quo_nxt[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= vld_in;
      end
      rem_r[j] <= rem_nxt;
      quo_r[j] <= quo_nxt;
      den_r[j] <= den_in;
      sb_r[j]  <= sb_stage;
    end
  end

  assign out_vld = vld_r[Q_W-1];
  assign quo     = quo_r[Q_W-1];
  assign sb_out  = sb_r[Q_W-1];

endmodule
`default_nettype wire

// ===== src/rti_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_sqrt
// Pipelined integer square root (floor), one root bit per stage, carrying
// the remainder x - root**2. Side data travels alongside.
// ----------------------------------------------------------------------------
module rti_sqrt #(
  parameter int X_W  = 98,
  parameter int SB_W = 1,
  localparam int R_W = (X_W + 1) / 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  logic [X_W-1:0]  x,
  input  logic [SB_W-1:0] sb_in,
  output logic            out_vld,
  output logic [R_W-1:0]  root,
  output logic [SB_W-1:0] sb_out
);

  localparam int T_W = 2 * R_W + 1;

  logic            vld_r  [R_W];
  logic [T_W-1:0]  rem_r  [R_W];
  logic [R_W-1:0]  root_r [R_W];
  logic [SB_W-1:0] sb_r   [R_W];

  genvar j;
  for (j = 0; j < R_W; j++) begin : g_stage
    localparam int B = R_W - 1 - j;
    logic            vld_in;
    logic [T_W-1:0]  rem_in;
    logic [R_W-1:0]  root_in;
    logic [SB_W-1:0] sb_stage;
    logic [T_W-1:0]  trial;
    logic [T_W-1:0]  rem_nxt;
    logic [R_W-1:0]  root_nxt;

    if (j == 0) begin : g_first
      assign vld_in   = in_vld;
      assign rem_in   = T_W'(x);
      assign root_in  = '0;
      assign sb_stage = sb_in;
    end else begin : g_next
      assign vld_in   = vld_r[j-1];
      assign rem_in   = rem_r[j-1];
      assign root_in  = root_r[j-1];
      assign sb_stage = sb_r[j-1];
    end

    // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
    always_comb begin
      trial    = (T_W'(root_in) << (B + 1)) + (T_W'(1) << (2 * B));
      rem_nxt  = rem_in;
      root_nxt = root_in;
      if (rem_in >= trial) begin
        rem_nxt     = rem_in - trial;
        root_nxt[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= vld_in;
      end
      rem_r[j]  <= rem_nxt;
      root_r[j] <= root_nxt;
      sb_r[j]   <= sb_stage;
    end
  end

  assign out_vld = vld_r[R_W-1];
  assign root    = root_r[R_W-1];
  assign sb_out  = sb_r[R_W-1];

endmodule
`default_nettype wire

// ===== src/rti_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_front
// Five-stage front end: edges, cross products, the four determinants and the
// face normal length squared, sign fold, then the barycentric and overflow
// tests ahead of the distance divider.
// ----------------------------------------------------------------------------
module rti_front import rti_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int DIST_WIDTH  = DIST_WIDTH_DEF,
  localparam int EW   = COORD_WIDTH + 1,
  localparam int NW   = 2 * EW + 1,
  localparam int DETW = NW + EW + 2,
  localparam int SW   = 2 * NW
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [3*COORD_WIDTH-1:0]      vtx_a,
  input  logic [3*COORD_WIDTH-1:0]      vtx_b,
  input  logic [3*COORD_WIDTH-1:0]      vtx_c,
  input  logic signed [COORD_WIDTH-1:0] org_x,
  input  logic signed [COORD_WIDTH-1:0] org_y,
  input  logic signed [COORD_WIDTH-1:0] org_z,
  input  logic signed [COORD_WIDTH-1:0] dir_x,
  input  logic signed [COORD_WIDTH-1:0] dir_y,
  input  logic signed [COORD_WIDTH-1:0] dir_z,
  input  logic signed [DIST_WIDTH-1:0]  min_t,
  input  logic signed [DIST_WIDTH-1:0]  best_t,
  output rti_ctl_t                      ctl,
  output logic [DETW-1:0]               t_num,
  output logic [DETW-1:0]               t_den,
  output logic [3*NW-1:0]               nrm,
  output logic [SW-1:0]                 nsq,
  output logic signed [DIST_WIDTH-1:0]  min_t_o,
  output logic signed [DIST_WIDTH-1:0]  best_t_o
);

  localparam int CMPW = DETW + DIST_WIDTH;

  function automatic logic signed [NW-1:0] xmul(
    input logic signed [EW-1:0] p, q, r, w);
    logic signed [2*EW-1:0] m0;
    logic signed [2*EW-1:0] m1;
    m0 = p * q;
    m1 = r * w;
    return NW'(m0) - NW'(m1);
  endfunction

  function automatic logic signed [DETW-1:0] dot3(
    input logic signed [NW-1:0] x0, x1, x2,
    input logic signed [EW-1:0] y0, y1, y2);
    logic signed [NW+EW-1:0] p0;
    logic signed [NW+EW-1:0] p1;
    logic signed [NW+EW-1:0] p2;
    p0 = x0 * y0;
    p1 = x1 * y1;
    p2 = x2 * y2;
    return DETW'(p0) + DETW'(p1) + DETW'(p2);
  endfunction

  // stage 1: edges and ray terms
  logic                          vld1_r;
  logic signed [EW-1:0]          e1_r [3];
  logic signed [EW-1:0]          e2_r [3];
  logic signed [EW-1:0]          s1_r [3];
  logic signed [EW-1:0]          d1_r [3];
  logic signed [EW-1:0]          e1_nxt [3];
  logic signed [EW-1:0]          e2_nxt [3];
  logic signed [EW-1:0]          s1_nxt [3];
  logic signed [EW-1:0]          d1_nxt [3];
  logic signed [COORD_WIDTH-1:0] org [3];
  logic signed [COORD_WIDTH-1:0] dir [3];
  logic signed [DIST_WIDTH-1:0]  min1_r, best1_r;

  assign org[0] = org_x;
  assign org[1] = org_y;
  assign org[2] = org_z;
  assign dir[0] = dir_x;
  assign dir[1] = dir_y;
  assign dir[2] = dir_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1_nxt[k] = EW'(signed'(vtx_a[k*COORD_WIDTH +: COORD_WIDTH]))
                - EW'(signed'(vtx_b[k*COORD_WIDTH +: COORD_WIDTH]));
      e2_nxt[k] = EW'(signed'(vtx_a[k*COORD_WIDTH +: COORD_WIDTH]))
                - EW'(signed'(vtx_c[k*COORD_WIDTH +: COORD_WIDTH]));
      s1_nxt[k] = EW'(signed'(vtx_a[k*COORD_WIDTH +: COORD_WIDTH])) - EW'(org[k]);
      d1_nxt[k] = EW'(dir[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
    end
    e1_r    <= e1_nxt;
    e2_r    <= e2_nxt;
    s1_r    <= s1_nxt;
    d1_r    <= d1_nxt;
    min1_r  <= min_t;
    best1_r <= best_t;
  end

  // stage 2: cross products n = e1 x e2, u = s x e2, v = e1 x s
  logic                         vld2_r;
  logic signed [NW-1:0]         n2_r [3];
  logic signed [NW-1:0]         u2_r [3];
  logic signed [NW-1:0]         v2_r [3];
  logic signed [EW-1:0]         s2_r [3];
  logic signed [EW-1:0]         d2_r [3];
  logic signed [DIST_WIDTH-1:0] min2_r, best2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    n2_r[0] <= xmul(e1_r[1], e2_r[2], e1_r[2], e2_r[1]);
    n2_r[1] <= xmul(e1_r[2], e2_r[0], e1_r[0], e2_r[2]);
    n2_r[2] <= xmul(e1_r[0], e2_r[1], e1_r[1], e2_r[0]);
    u2_r[0] <= xmul(s1_r[1], e2_r[2], s1_r[2], e2_r[1]);
    u2_r[1] <= xmul(s1_r[2], e2_r[0], s1_r[0], e2_r[2]);
    u2_r[2] <= xmul(s1_r[0], e2_r[1], s1_r[1], e2_r[0]);
    v2_r[0] <= xmul(e1_r[1], s1_r[2], e1_r[2], s1_r[1]);
    v2_r[1] <= xmul(e1_r[2], s1_r[0], e1_r[0], s1_r[2]);
    v2_r[2] <= xmul(e1_r[0], s1_r[1], e1_r[1], s1_r[0]);
    s2_r    <= s1_r;
    d2_r    <= d1_r;
    min2_r  <= min1_r;
    best2_r <= best1_r;
  end

  // stage 3: determinants and |n|^2
  logic                         vld3_r;
  logic signed [DETW-1:0]       dd3_r, dt3_r, db3_r, dg3_r;
  logic signed [NW-1:0]         n3_r [3];
  logic [SW-1:0]                sq3_r;
  logic [SW-1:0]                sq_nxt;
  logic signed [2*NW-1:0]       nn [3];
  logic signed [DIST_WIDTH-1:0] min3_r, best3_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nn[k] = n2_r[k] * n2_r[k];
    end
    sq_nxt = SW'(unsigned'(nn[0])) + SW'(unsigned'(nn[1])) + SW'(unsigned'(nn[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else begin
      vld3_r <= vld2_r;
    end
    dd3_r   <= dot3(n2_r[0], n2_r[1], n2_r[2], d2_r[0], d2_r[1], d2_r[2]);
    dt3_r   <= dot3(n2_r[0], n2_r[1], n2_r[2], s2_r[0], s2_r[1], s2_r[2]);
    db3_r   <= dot3(u2_r[0], u2_r[1], u2_r[2], d2_r[0], d2_r[1], d2_r[2]);
    dg3_r   <= dot3(v2_r[0], v2_r[1], v2_r[2], d2_r[0], d2_r[1], d2_r[2]);
    n3_r    <= n2_r;
    sq3_r   <= sq_nxt;
    min3_r  <= min2_r;
    best3_r <= best2_r;
  end

  // stage 4: fold the sign of D into the determinant terms
  logic                         vld4_r;
  logic                         dz4_r, tneg4_r;
  logic [DETW-1:0]              dabs4_r, tabs4_r;
  logic signed [DETW-1:0]       db4_r, dg4_r;
  logic signed [NW-1:0]         n4_r [3];
  logic [SW-1:0]                sq4_r;
  logic signed [DIST_WIDTH-1:0] min4_r, best4_r;
  logic                         dneg;

  assign dneg = dd3_r[DETW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else begin
      vld4_r <= vld3_r;
    end
    dz4_r   <= (dd3_r == '0);
    dabs4_r <= dneg ? unsigned'(-dd3_r) : unsigned'(dd3_r);
    db4_r   <= dneg ? -db3_r : db3_r;
    dg4_r   <= dneg ? -dg3_r : dg3_r;
    tabs4_r <= dt3_r[DETW-1] ? unsigned'(-dt3_r) : unsigned'(dt3_r);
    tneg4_r <= dt3_r[DETW-1] ^ dneg;
    n4_r    <= n3_r;
    sq4_r   <= sq3_r;
    min4_r  <= min3_r;
    best4_r <= best3_r;
  end

  // stage 5: inside test and quotient overflow check
  logic signed [DETW:0] wsum;
  logic                 ok_nxt, ovf_nxt;
  rti_ctl_t             ctl5_r;
  logic [DETW-1:0]      tabs5_r, dabs5_r;
  logic [3*NW-1:0]      n5_r;
  logic [SW-1:0]        sq5_r;
  logic signed [DIST_WIDTH-1:0] min5_r, best5_r;

  always_comb begin
    wsum    = (DETW+1)'(db4_r) + (DETW+1)'(dg4_r);
    ok_nxt  = !dz4_r && (db4_r > 0) && (dg4_r > 0) && (wsum < signed'({1'b0, dabs4_r}));
    ovf_nxt = ((CMPW'(tabs4_r) << T_FRAC) >= (CMPW'(dabs4_r) << DIST_WIDTH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl5_r <= '0;
    end else begin
      ctl5_r.valid <= vld4_r;
      ctl5_r.ok    <= ok_nxt;
      ctl5_r.ovf   <= ovf_nxt;
      ctl5_r.tneg  <= tneg4_r;
    end
    tabs5_r <= tabs4_r;
    dabs5_r <= dabs4_r;
    n5_r    <= {n4_r[2], n4_r[1], n4_r[0]};
    sq5_r   <= sq4_r;
    min5_r  <= min4_r;
    best5_r <= best4_r;
  end

  assign ctl      = ctl5_r;
  assign t_num    = tabs5_r;
  assign t_den    = dabs5_r;
  assign nrm      = n5_r;
  assign nsq      = sq5_r;
  assign min_t_o  = min5_r;
  assign best_t_o = best5_r;

endmodule
`default_nettype wire

// ===== src/ray_triangle_intersect.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Ray / triangle hit test by Cramer's rule, fully pipelined, with distance
// and unit face normal on a hit.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | start, busy         | in_origin_*, in_dir_*, in_min_t, in_best_t
//  result   | out_strobe          | out_hit, out_hit_t, out_normal_*
//  config   | cfg_we              | cfg_index, cfg_data
//
//  One beat in per cycle, one result per beat; busy stays low.
//  Stages: five determinant stages, one stage per bit of the distance divider,
//  the distance saturation register, one per root bit of the normal length
//  square root, sixteen for the normal divide, and the output register.
//  Reset (synchronous) clears the valid bits and the vertex registers.
//  Results are offered for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module ray_triangle_intersect import rti_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int DIST_WIDTH  = DIST_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_origin_x,
  input  logic signed [COORD_WIDTH-1:0] in_origin_y,
  input  logic signed [COORD_WIDTH-1:0] in_origin_z,
  input  logic signed [COORD_WIDTH-1:0] in_dir_x,
  input  logic signed [COORD_WIDTH-1:0] in_dir_y,
  input  logic signed [COORD_WIDTH-1:0] in_dir_z,
  input  logic signed [DIST_WIDTH-1:0]  in_min_t,
  input  logic signed [DIST_WIDTH-1:0]  in_best_t,
  output logic                          out_strobe,
  output logic                          out_hit,
  output logic signed [DIST_WIDTH-1:0]  out_hit_t,
  output logic signed [NRM_W-1:0]       out_normal_x,
  output logic signed [NRM_W-1:0]       out_normal_y,
  output logic signed [NRM_W-1:0]       out_normal_z,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [3*COORD_WIDTH-1:0]      cfg_data
);

  localparam int EW   = COORD_WIDTH + 1;
  localparam int NW   = 2 * EW + 1;
  localparam int DETW = NW + EW + 2;
  localparam int SW   = 2 * NW;
  localparam int XW   = SW + NRM_SHIFT;
  localparam int RW   = (XW + 1) / 2;
  localparam int TSB_W = 3 + 2 * DIST_WIDTH + 3 * NW + SW;
  localparam int QSB_W = 1 + DIST_WIDTH + 3 + 3 * NW;
  localparam logic signed [DIST_WIDTH-1:0] T_MAX = {1'b0, {(DIST_WIDTH-1){1'b1}}};
  localparam logic signed [DIST_WIDTH-1:0] T_MIN = {1'b1, {(DIST_WIDTH-1){1'b0}}};

  assign busy = 1'b0;

  // vertex registers
  logic [3*COORD_WIDTH-1:0] vtx_a_r, vtx_b_r, vtx_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vtx_a_r <= '0;
      vtx_b_r <= '0;
      vtx_c_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VERTEX_A: vtx_a_r <= cfg_data;
        REG_VERTEX_B: vtx_b_r <= cfg_data;
        REG_VERTEX_C: vtx_c_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // determinant front end
  rti_ctl_t                     fr_ctl;
  logic [DETW-1:0]              fr_tnum, fr_tden;
  logic [3*NW-1:0]              fr_nrm;
  logic [SW-1:0]                fr_nsq;
  logic signed [DIST_WIDTH-1:0] fr_min, fr_best;

  rti_front #(
    .COORD_WIDTH(COORD_WIDTH),
    .DIST_WIDTH (DIST_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start && !busy),
    .vtx_a   (vtx_a_r),
    .vtx_b   (vtx_b_r),
    .vtx_c   (vtx_c_r),
    .org_x   (in_origin_x),
    .org_y   (in_origin_y),
    .org_z   (in_origin_z),
    .dir_x   (in_dir_x),
    .dir_y   (in_dir_y),
    .dir_z   (in_dir_z),
    .min_t   (in_min_t),
    .best_t  (in_best_t),
    .ctl     (fr_ctl),
    .t_num   (fr_tnum),
    .t_den   (fr_tden),
    .nrm     (fr_nrm),
    .nsq     (fr_nsq),
    .min_t_o (fr_min),
    .best_t_o(fr_best)
  );

  // distance divider: |Dt| * 2^16 / |D|
  logic                         td_vld;
  logic [DIST_WIDTH-1:0]        td_q;
  logic [TSB_W-1:0]             td_sb;
  logic                         td_ok, td_ovf, td_tneg;
  logic signed [DIST_WIDTH-1:0] td_min, td_best;
  logic [3*NW-1:0]              td_nrm;
  logic [SW-1:0]                td_nsq;

  rti_div #(
    .NUM_W(DETW + T_FRAC),
    .DEN_W(DETW),
    .Q_W  (DIST_WIDTH),
    .SB_W (TSB_W)
  ) u_tdiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (fr_ctl.valid),
    .num    ({fr_tnum, {T_FRAC{1'b0}}}),
    .den    (fr_tden),
    .sb_in  ({fr_ctl.ok, fr_ctl.ovf, fr_ctl.tneg, fr_min, fr_best, fr_nrm, fr_nsq}),
    .out_vld(td_vld),
    .quo    (td_q),
    .sb_out (td_sb)
  );

  assign {td_ok, td_ovf, td_tneg, td_min, td_best, td_nrm, td_nsq} = td_sb;

  // saturate the distance, apply the bound window, split the normal
  logic signed [DIST_WIDTH-1:0] tq_nxt;
  logic                         hit_nxt;
  logic [2:0]                   sgn_nxt;
  logic [3*NW-1:0]              mag_nxt;
  logic signed [NW-1:0]         nk;
  logic                         vt_r, hit_t_r;
  logic signed [DIST_WIDTH-1:0] tq_t_r;
  logic [2:0]                   sgn_t_r;
  logic [3*NW-1:0]              mag_t_r;
  logic [SW-1:0]                nsq_t_r;

  always_comb begin
    if (!td_tneg) begin
      if (td_ovf || td_q[DIST_WIDTH-1]) tq_nxt = T_MAX;
      else                              tq_nxt = signed'(td_q);
    end else begin
      if (td_ovf || (td_q[DIST_WIDTH-1] && (|td_q[DIST_WIDTH-2:0]))) tq_nxt = T_MIN;
      else                                                           tq_nxt = -signed'(td_q);
    end
    hit_nxt = td_ok && (td_min < tq_nxt) && (tq_nxt < td_best);
    for (int k = 0; k < 3; k++) begin
      nk         = signed'(td_nrm[k*NW +: NW]);
      sgn_nxt[k] = nk[NW-1];
      mag_nxt[k*NW +: NW] = nk[NW-1] ? unsigned'(-nk) : unsigned'(nk);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r <= 1'b0;
    end else begin
      vt_r <= td_vld;
    end
    hit_t_r <= hit_nxt;
    tq_t_r  <= tq_nxt;
    sgn_t_r <= sgn_nxt;
    mag_t_r <= mag_nxt;
    nsq_t_r <= td_nsq;
  end

  // normal length: floor(sqrt(|n|^2 * 2^28))
  logic                         sq_vld;
  logic [RW-1:0]                sq_root;
  logic [QSB_W-1:0]             sq_sb;
  logic                         sq_hit;
  logic signed [DIST_WIDTH-1:0] sq_tq;
  logic [2:0]                   sq_sgn;
  logic [3*NW-1:0]              sq_mag;

  rti_sqrt #(
    .X_W (XW),
    .SB_W(QSB_W)
  ) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (vt_r),
    .x      ({nsq_t_r, {NRM_SHIFT{1'b0}}}),
    .sb_in  ({hit_t_r, tq_t_r, sgn_t_r, mag_t_r}),
    .out_vld(sq_vld),
    .root   (sq_root),
    .sb_out (sq_sb)
  );

  assign {sq_hit, sq_tq, sq_sgn, sq_mag} = sq_sb;

  // normal components: |n_k| * 2^28 / length
  logic                         nx_vld, ny_vld, nz_vld;
  logic [NRM_W-1:0]             nx_q, ny_q, nz_q;
  logic                         nx_hit;
  logic signed [DIST_WIDTH-1:0] nx_tq;
  logic                         nx_sgn, ny_sgn, nz_sgn;

  rti_div #(
    .NUM_W(NW + NRM_SHIFT),
    .DEN_W(RW),
    .Q_W  (NRM_W),
    .SB_W (DIST_WIDTH + 2)
  ) u_ndiv_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (sq_vld),
    .num    ({sq_mag[0 +: NW], {NRM_SHIFT{1'b0}}}),
    .den    (sq_root),
    .sb_in  ({sq_hit, sq_tq, sq_sgn[0]}),
    .out_vld(nx_vld),
    .quo    (nx_q),
    .sb_out ({nx_hit, nx_tq, nx_sgn})
  );

  rti_div #(
    .NUM_W(NW + NRM_SHIFT),
    .DEN_W(RW),
    .Q_W  (NRM_W),
    .SB_W (1)
  ) u_ndiv_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (sq_vld),
    .num    ({sq_mag[NW +: NW], {NRM_SHIFT{1'b0}}}),
    .den    (sq_root),
    .sb_in  (sq_sgn[1]),
    .out_vld(ny_vld),
    .quo    (ny_q),
    .sb_out (ny_sgn)
  );

  rti_div #(
    .NUM_W(NW + NRM_SHIFT),
    .DEN_W(RW),
    .Q_W  (NRM_W),
    .SB_W (1)
  ) u_ndiv_z (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (sq_vld),
    .num    ({sq_mag[2*NW +: NW], {NRM_SHIFT{1'b0}}}),
    .den    (sq_root),
    .sb_in  (sq_sgn[2]),
    .out_vld(nz_vld),
    .quo    (nz_q),
    .sb_out (nz_sgn)
  );

  // clamp to one, restore the sign, drop everything on a miss
  function automatic logic [NRM_W-1:0] nrm_fix(
    input logic [NRM_W-1:0] q, input logic neg, input logic hit);
    logic [NRM_W-1:0] m;
    m = (q > NRM_ONE) ? NRM_ONE : q;
    if (!hit)     return '0;
    else if (neg) return -m;
    else          return m;
  endfunction

  logic                         out_strobe_r, out_hit_r;
  logic signed [DIST_WIDTH-1:0] out_hit_t_r;
  logic [NRM_W-1:0]             out_nx_r, out_ny_r, out_nz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= nx_vld;
    end
    out_hit_r   <= nx_hit;
    out_hit_t_r <= nx_hit ? nx_tq : '0;
    out_nx_r    <= nrm_fix(nx_q, nx_sgn, nx_hit);
    out_ny_r    <= nrm_fix(ny_q, ny_sgn, nx_hit);
    out_nz_r    <= nrm_fix(nz_q, nz_sgn, nx_hit);
  end

  assign out_strobe   = out_strobe_r;
  assign out_hit      = out_hit_r;
  assign out_hit_t    = out_hit_t_r;
  assign out_normal_x = signed'(out_nx_r);
  assign out_normal_y = signed'(out_ny_r);
  assign out_normal_z = signed'(out_nz_r);

  // the three normal dividers must stay in lock step
  a_ndiv_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (nx_vld == ny_vld) && (ny_vld == nz_vld))
    else $error("normal dividers out of step");

  // a miss carries an all-zero payload
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_hit) |->
      (out_hit_t == '0) && (out_normal_x == '0) && (out_normal_y == '0) &&
      (out_normal_z == '0))
    else $error("miss with nonzero payload");

  // nothing leaves straight out of reset
  a_reset_quiet: assert property (@(posedge clk) $rose(rst_n) |-> !out_strobe)
    else $error("result strobe straight after reset");

endmodule
`default_nettype wire

// ===== verif/ray_triangle_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_checker
// Watches the ray, result and vertex ports of ray_triangle_intersect. Keeps
// its own copy of the three vertex registers and works out the expected hit
// record for every accepted ray, then compares each result beat field by field.
// ----------------------------------------------------------------------------
module ray_triangle_checker import rti_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic signed [15:0]        in_origin_x,
  input  logic signed [15:0]        in_origin_y,
  input  logic signed [15:0]        in_origin_z,
  input  logic signed [15:0]        in_dir_x,
  input  logic signed [15:0]        in_dir_y,
  input  logic signed [15:0]        in_dir_z,
  input  logic signed [31:0]        in_min_t,
  input  logic signed [31:0]        in_best_t,
  input  logic                      out_strobe,
  input  logic                      out_hit,
  input  logic signed [31:0]        out_hit_t,
  input  logic signed [NRM_W-1:0]   out_normal_x,
  input  logic signed [NRM_W-1:0]   out_normal_y,
  input  logic signed [NRM_W-1:0]   out_normal_z,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [47:0]               cfg_data,
  output int                        fail_count,
  output int                        pending
);

  typedef logic signed [127:0] wide_t;
  typedef logic [127:0] uwide_t;

  typedef struct {
    logic              hit;
    logic signed [31:0] hit_t;
    logic signed [15:0] nx, ny, nz;
  } hit_rec_t;

  logic [47:0] vertex [3];
  hit_rec_t    hits_due [$];

  function automatic longint coord(input logic [47:0] v, input int k);
    logic signed [15:0] c;
    c = v[k*16 +: 16];
    return longint'(c);
  endfunction

  function automatic wide_t dot3(input longint p [3], input longint q [3]);
    return wide_t'(p[0]) * wide_t'(q[0]) + wide_t'(p[1]) * wide_t'(q[1])
         + wide_t'(p[2]) * wide_t'(q[2]);
  endfunction

  function automatic void cross3(input longint p [3], input longint q [3],
                                 output longint r [3]);
    r[0] = p[1] * q[2] - p[2] * q[1];
    r[1] = p[2] * q[0] - p[0] * q[2];
    r[2] = p[0] * q[1] - p[1] * q[0];
  endfunction

  function automatic hit_rec_t trace_triangle(input longint org [3], input longint dir [3],
                                              input longint lo_t, input longint hi_t);
    hit_rec_t r;
    longint   e1 [3], e2 [3], s [3], n [3], u [3], v [3];
    wide_t    det, det_t, det_b, det_g, sq;
    uwide_t   num, quo, s28, cc;
    longint   tq, lim;
    logic [63:0] root, cand;
    r = '{hit: 1'b0, hit_t: '0, nx: '0, ny: '0, nz: '0};
    for (int k = 0; k < 3; k++) begin
      e1[k] = coord(vertex[0], k) - coord(vertex[1], k);
      e2[k] = coord(vertex[0], k) - coord(vertex[2], k);
      s[k]  = coord(vertex[0], k) - org[k];
    end
    cross3(e1, e2, n);
    cross3(s, e2, u);
    cross3(e1, s, v);
    det = dot3(n, dir);
    det_t = dot3(n, s);
    det_b = dot3(u, dir);
    det_g = dot3(v, dir);
    if (det == 0) return r;
    if (det < 0) begin
      det = -det; det_t = -det_t; det_b = -det_b; det_g = -det_g;
    end
    if (det_b <= 0 || det_g <= 0 || det_b + det_g >= det) return r;
    num = uwide_t'(det_t < 0 ? -det_t : det_t) << 16;
    quo = num / uwide_t'(det);
    lim = 64'sd2147483647;
    if (det_t < 0) tq = (quo > uwide_t'(lim + 1)) ? -lim - 1 : -longint'(quo);
    else           tq = (quo > uwide_t'(lim)) ? lim : longint'(quo);
    if (!(lo_t < tq && tq < hi_t)) return r;
    // unit normal: scale by 2^28 before the root so the quotient lands in Q1.14
    sq = wide_t'(n[0]) * n[0] + wide_t'(n[1]) * n[1] + wide_t'(n[2]) * n[2];
    s28 = uwide_t'(sq) << 28;
    root = '0;
    for (int i = 62; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      cc = {64'd0, cand} * {64'd0, cand};
      if (s28 >= cc) root = cand;
    end
    r.hit = 1'b1;
    r.hit_t = tq[31:0];
    for (int k = 0; k < 3; k++) begin
      logic [15:0] comp;
      quo = (uwide_t'(n[k] < 0 ? -n[k] : n[k]) << 28) / {64'd0, root};
      if (quo > 16384) quo = 16384;
      comp = (n[k] < 0) ? -quo[15:0] : quo[15:0];
      if (k == 0) r.nx = comp;
      else if (k == 1) r.ny = comp;
      else r.nz = comp;
    end
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    hit_rec_t due;
    longint   org [3], dir [3];
    if (!rst_n) begin
      vertex = '{48'd0, 48'd0, 48'd0};
      hits_due.delete();
    end else begin
      if (start && !busy) begin
        org = '{longint'(in_origin_x), longint'(in_origin_y), longint'(in_origin_z)};
        dir = '{longint'(in_dir_x), longint'(in_dir_y), longint'(in_dir_z)};
        hits_due.push_back(trace_triangle(org, dir, longint'(in_min_t),
                                          longint'(in_best_t)));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_VERTEX_A: vertex[0] = cfg_data;
          REG_VERTEX_B: vertex[1] = cfg_data;
          REG_VERTEX_C: vertex[2] = cfg_data;
          default: ;  // drop writes to unknown indexes
        endcase
      end
      if (out_strobe) begin
        if (hits_due.size() == 0) begin
          $error("result beat with no ray outstanding");
          fail_count++;
        end else begin
          due = hits_due.pop_front();
          if (out_hit !== due.hit) begin
            $error("hit expected %0d got %0d", due.hit, out_hit);
            fail_count++;
          end
          if (out_hit_t !== due.hit_t) begin
            $error("hit_t expected %0d got %0d", due.hit_t, out_hit_t);
            fail_count++;
          end
          if (out_normal_x !== due.nx) begin
            $error("normal_x expected %0d got %0d", due.nx, out_normal_x);
            fail_count++;
          end
          if (out_normal_y !== due.ny) begin
            $error("normal_y expected %0d got %0d", due.ny, out_normal_y);
            fail_count++;
          end
          if (out_normal_z !== due.nz) begin
            $error("normal_z expected %0d got %0d", due.nz, out_normal_z);
            fail_count++;
          end
        end
      end
    end
    pending = hits_due.size();
  end

endmodule

// ===== verif/ray_triangle_intersect_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_intersect_tb
// Drives rays into ray_triangle_intersect under several vertex settings: a
// directed set of corner cases, then random rays aimed mostly into the
// triangle with some pure noise. A checker beside the block predicts results.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_tb;
  import rti_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 120;
  localparam int PHASE_RAYS = 325;
  localparam int QUIET_TAIL = 100;
  localparam logic signed [31:0] T_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] T_MIN = 32'sh80000000;

  logic clk, rst_n, start, busy;
  logic signed [15:0] in_origin_x, in_origin_y, in_origin_z;
  logic signed [15:0] in_dir_x, in_dir_y, in_dir_z;
  logic signed [31:0] in_min_t, in_best_t;
  logic out_strobe, out_hit;
  logic signed [31:0] out_hit_t;
  logic signed [NRM_W-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [47:0] cfg_data;
  int fail_count, pending;
  int idle_cycles;
  longint tri_pt [3][3];

  ray_triangle_intersect u_top (.*);

  ray_triangle_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    {in_origin_x, in_origin_y, in_origin_z} <= '0;
    {in_dir_x, in_dir_y, in_dir_z} <= '0;
    in_min_t <= '0;
    in_best_t <= '0;
  end

  // Stall watchdog: count cycles with no beat on either channel.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ray_triangle_intersect verification failed");
      $finish;
    end
  end

  task automatic shoot(input longint ox, oy, oz, dx, dy, dz,
                       input logic signed [31:0] lo_t, hi_t);
    start <= 1'b1;
    in_origin_x <= ox[15:0];
    in_origin_y <= oy[15:0];
    in_origin_z <= oz[15:0];
    in_dir_x <= dx[15:0];
    in_dir_y <= dy[15:0];
    in_dir_z <= dz[15:0];
    in_min_t <= lo_t;
    in_best_t <= hi_t;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_triangle(input longint v [3][3]);
    tri_pt = v;
    for (int i = 0; i < 3; i++)
      set_reg(CFG_IDX_W'(i), {v[i][2][15:0], v[i][1][15:0], v[i][0][15:0]});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic longint rnd_coord(input int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic signed [31:0] rnd_t();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($urandom_range(0, 8 << 16)) - 32'sd65536;
      2: return T_MIN;
      default: return 32'($urandom_range(0, 1 << 17));
    endcase
  endfunction

  // Aim a ray at a random interior point, scaled and sometimes reversed.
  task automatic aimed_ray();
    longint org [3], dir [3];
    int wb, wg, sh;
    logic signed [31:0] lo_t, hi_t;
    bit fits;
    wb = $urandom_range(1, 254);
    wg = $urandom_range(1, 255 - wb);
    for (int k = 0; k < 3; k++) begin
      org[k] = rnd_coord(16384);
      dir[k] = tri_pt[0][k] + ((tri_pt[1][k] - tri_pt[0][k]) * wb
             + (tri_pt[2][k] - tri_pt[0][k]) * wg) / 256 - org[k];
    end
    sh = $urandom_range(0, 3);
    do begin
      fits = 1'b1;
      for (int k = 0; k < 3; k++) begin
        dir[k] = dir[k] >>> sh;
        if (dir[k] > 32767 || dir[k] < -32768) fits = 1'b0;
      end
      sh = 1;
    end while (!fits);
    if ($urandom_range(0, 5) == 0)
      for (int k = 0; k < 3; k++) dir[k] = -dir[k];
    lo_t = ($urandom_range(0, 2) == 0) ? rnd_t() : 32'sd0;
    hi_t = ($urandom_range(0, 1) == 0) ? T_MAX : rnd_t();
    shoot(org[0], org[1], org[2], dir[0], dir[1], dir[2], lo_t, hi_t);
  endtask

  task automatic noise_ray();
    shoot($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  function automatic longint extreme_coord();
    case ($urandom_range(0, 3))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return rnd_coord(32767);
    endcase
  endfunction

  initial begin
    longint tri_set [3][3];
    longint step;
    int kind;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // vertices still at reset: every ray is degenerate
    shoot(-32768, -32768, -32768, -32768, -32768, -32768, T_MIN, T_MIN);
    shoot(32767, 32767, 32767, 32767, 32767, 32767, T_MAX, T_MAX);
    drain();

    // unit right triangle in the z = 0 plane
    set_triangle('{'{0, 0, 0}, '{256, 0, 0}, '{0, 256, 0}});
    shoot(64, 64, -256, 0, 0, 256, 0, T_MAX);           // plain hit, t = 1
    shoot(64, 64, -256, 256, 0, 0, 0, T_MAX);           // parallel
    shoot(256, 256, -256, 0, 0, 256, 0, T_MAX);         // misses outside
    shoot(0, 128, -256, 0, 0, 256, T_MIN, T_MAX);       // on an edge
    shoot(128, 128, -256, 0, 0, 256, T_MIN, T_MAX);     // on the long edge
    shoot(64, 64, -256, 0, 0, 256, 5 << 16, 5 << 16);   // empty window
    shoot(64, 64, 256, 0, 0, 256, T_MIN, T_MAX);        // hit behind origin
    shoot(64, 64, -256, 0, 0, 256, 0, 32'sd65536);      // t equals bound
    shoot(64, 64, -256, 0, 0, 256, 0, 32'sd65537);
    shoot(64, 64, -256, 0, 0, 256, 32'sd65536, T_MAX);
    shoot(64, 64, 256, 0, 0, -256, 0, T_MAX);           // flipped determinant
    drain();
    pause(DRAIN_CYCLES / 4);

    // far plane with a tiny step: quotient saturates both ways
    set_triangle('{'{0, 0, 32767}, '{256, 0, 32767}, '{0, 256, 32767}});
    shoot(64, 64, -32768, 0, 0, 1, T_MIN, T_MAX);
    shoot(64, 64, -32768, 0, 0, -1, T_MIN, T_MAX);
    shoot(64, 64, -32768, 0, 0, 1, T_MIN, 32'sh7ffffffe);
    drain();
    set_reg(REG_UNUSED, 48'($urandom));
    cfg_we <= 1'b0;
    shoot(64, 64, -32768, 0, 0, 1, T_MIN, T_MAX);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++)
          case (phase)
            1: tri_set[i][k] = extreme_coord();
            2: begin
              // collinear vertices: a flat triangle never hits
              step = (k + 1) * 37;
              tri_set[i][k] = -2000 + i * step;
            end
            default: tri_set[i][k] = rnd_coord(16384);
          endcase
      set_triangle(tri_set);
      for (int n = 0; n < PHASE_RAYS; n++) begin
        kind = $urandom_range(0, 3);
        if (kind == 0) noise_ray();
        else aimed_ray();
        if (!(phase == 3 && n >= PHASE_RAYS - QUIET_TAIL) && $urandom_range(0, 4) == 0)
          pause($urandom_range(1, 4));
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("ray_triangle_intersect verification clean");
    else
      $display("ray_triangle_intersect verification failed");
    $finish;
  end

endmodule
